### rtl/nfd_pkg.sv
// Package for the NFC information frame deframer: payload structs, result
// kind codes, frame constants and the deframer phase encoding.
// No dependencies.
`default_nettype none

package nfd_pkg;

    localparam int unsigned LimitWidth = 16;

    localparam logic [7:0]            START_FIRST  = 8'h00;
    localparam logic [7:0]            START_SECOND = 8'hFF;
    localparam logic [7:0]            TFI_ERROR    = 8'h7F;
    localparam logic [7:0]            TFI_TO_HOST  = 8'hD5;
    localparam logic [LimitWidth-1:0] LIMIT_RESET  = 16'd263;
    localparam logic [LimitWidth-1:0] COUNT_MAX    = '1;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_LEN_BAD  = 3'd2,
        KIND_DATA_BAD = 3'd3,
        KIND_APP_ERR  = 3'd4,
        KIND_BAD_ID   = 3'd5,
        KIND_NO_START = 3'd6
    } kind_t;

    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_LEN  = 7'b0000010,
        PH_LCS  = 7'b0000100,
        PH_TFI  = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_DCS  = 7'b0100000,
        PH_IDLE = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_read;
    } nfd_in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last_payload;
    } nfd_out_t;

endpackage

`default_nettype wire

### rtl/nfc_frame_deframer.sv
// Top level of the NFC information frame deframer: start-code hunt, length,
// identifier and data checksum checks, payload pass-through.
// Depends on nfd_pkg.
`default_nettype none

// Channel   Signals                          Moves
// -------   ------------------------------   ---------------------------------
// in        in_valid / in_ready / in_data    one received byte per transaction
// out       out_valid / out_ready / out_data one result (payload or outcome)
// cfg       cfg_wr_en / cfg_wr_data          search limit, taken on any edge
//
// An accepted byte lands in the input register; when the output has room the
// frame logic consumes it and, if it causes a result, loads the output
// register. One byte per cycle is sustained while the consumer takes results;
// the only loop is the phase/checksum update. rst_n clears the phase, counters,
// valid flags and reloads the search limit with 263. A stalled output register
// holds the input register, and in_ready drops once both are occupied.

module nfc_frame_deframer
    import nfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire nfd_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output nfd_out_t                   out_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LimitWidth-1:0] cfg_wr_data
);

    logic [LimitWidth-1:0] limit_reg;
    logic                  in_valid_reg;
    nfd_in_t               in_reg;
    logic                  out_valid_reg;
    nfd_out_t              out_reg;

    phase_t                phase_reg, phase_next;
    logic                  saw_zero_reg, saw_zero_next;
    logic [LimitWidth-1:0] hunt_count_reg, hunt_count_next;
    logic [7:0]            frame_length_reg, frame_length_next;
    logic [7:0]            remaining_reg, remaining_next;
    logic [7:0]            running_sum_reg, running_sum_next;

    logic                  advance;
    logic                  emit;
    nfd_out_t              emit_data;

    phase_t                eff_phase;
    logic                  eff_saw_zero;
    logic [LimitWidth-1:0] eff_count;
    logic [LimitWidth-1:0] count_inc;
    logic [7:0]            rx;

    // Consume the held byte only when the output register can take a result.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign rx        = in_reg.rx_byte;

    // A fresh read restarts the hunt before this byte is examined.
    assign eff_phase    = in_reg.new_read ? PH_HUNT : phase_reg;
    assign eff_saw_zero = in_reg.new_read ? 1'b0 : saw_zero_reg;
    assign eff_count    = in_reg.new_read ? '0 : hunt_count_reg;
    assign count_inc    = (eff_count == COUNT_MAX) ? eff_count : eff_count + 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        saw_zero_next     = saw_zero_reg;
        hunt_count_next   = hunt_count_reg;
        frame_length_next = frame_length_reg;
        remaining_next    = remaining_reg;
        running_sum_next  = running_sum_reg;
        emit              = 1'b0;
        emit_data.kind         = KIND_PAYLOAD;
        emit_data.value        = 8'd0;
        emit_data.last_payload = 1'b0;

        case (eff_phase)
            PH_HUNT:
            begin
                hunt_count_next = count_inc;
                saw_zero_next   = (rx == START_FIRST);
                if (eff_saw_zero && rx == START_SECOND && count_inc < limit_reg)
                begin
                    phase_next = PH_LEN;
                end
                else if (count_inc >= limit_reg)
                begin
                    phase_next     = PH_IDLE;
                    emit           = 1'b1;
                    emit_data.kind = KIND_NO_START;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                frame_length_next = rx;
                phase_next        = PH_LCS;
            end
            PH_LCS:
            begin
                // Zero length fails even when the checksum happens to match.
                if (8'(frame_length_reg + rx) != 8'd0 || frame_length_reg == 8'd0)
                begin
                    phase_next     = PH_IDLE;
                    emit           = 1'b1;
                    emit_data.kind = KIND_LEN_BAD;
                end
                else
                begin
                    phase_next = PH_TFI;
                end
            end
            PH_TFI:
            begin
                if (rx == TFI_ERROR)
                begin
                    phase_next     = PH_IDLE;
                    emit           = 1'b1;
                    emit_data.kind = KIND_APP_ERR;
                end
                else if (rx != TFI_TO_HOST)
                begin
                    phase_next     = PH_IDLE;
                    emit           = 1'b1;
                    emit_data.kind = KIND_BAD_ID;
                end
                else
                begin
                    running_sum_next = rx;
                    remaining_next   = frame_length_reg - 8'd1;
                    phase_next = (frame_length_reg == 8'd1) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA:
            begin
                running_sum_next       = running_sum_reg + rx;
                remaining_next         = remaining_reg - 8'd1;
                emit                   = 1'b1;
                emit_data.kind         = KIND_PAYLOAD;
                emit_data.value        = rx;
                emit_data.last_payload = (remaining_reg == 8'd1);
                phase_next = (remaining_reg == 8'd1) ? PH_DCS : PH_DATA;
            end
            PH_DCS:
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                if (8'(running_sum_reg + rx) != 8'd0)
                begin
                    emit_data.kind = KIND_DATA_BAD;
                end
                else
                begin
                    emit_data.kind  = KIND_GOOD;
                    emit_data.value = frame_length_reg - 8'd1;
                end
            end
            default:
            begin
                // Drop trailing bytes until the next fresh read.
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Search limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Input register: load on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // Frame state: advance once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            saw_zero_reg     <= 1'b0;
            hunt_count_reg   <= '0;
            frame_length_reg <= 8'd0;
            remaining_reg    <= 8'd0;
            running_sum_reg  <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            saw_zero_reg     <= saw_zero_next;
            hunt_count_reg   <= hunt_count_next;
            frame_length_reg <= frame_length_next;
            remaining_reg    <= remaining_next;
            running_sum_reg  <= running_sum_next;
        end
    end

    // Output register: hold until taken, reload when a result is produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= emit_data;
        end
    end

    // Checks on the frame logic.
    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.last_payload |-> out_reg.kind == KIND_PAYLOAD)
        else $error("last marker on a non-payload result");

    a_outcome_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && emit_data.kind != KIND_PAYLOAD |=> phase_reg == PH_IDLE)
        else $error("outcome reported without leaving the frame");

    a_good_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_GOOD
        |-> out_reg.value == 8'(frame_length_reg - 8'd1))
        else $error("good frame length mismatch");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while both registers are occupied");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

endmodule

`default_nettype wire
